FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion forms shared by the RTL, on i_clk and i_rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property checked on every clock outside reset.
`define ASSERT_CLK(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("assertion failed");

// Condition that must never hold outside reset.
`define ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

FILE: rtl/ufd_pkg.sv
// ----------------------------------------------------------------------------
// ufd_pkg
// Types, status codes and constants of the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ufd_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [1:0] t_status;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_BAD_FIRST = 2'd1;
    localparam t_status ST_BAD_CONT  = 2'd2;

    localparam logic [7:0] CONT_MASK    = 8'hC0;
    localparam logic [7:0] CONT_TAG     = 8'h80;
    localparam logic [5:0] PAYLOAD_MASK = 6'h3F;

    typedef struct packed {
        logic [31:0] code_point;
        t_status     status;
        logic [3:0]  bytes_used;
        logic        last_result;
    } t_result;

    typedef struct packed {
        logic [31:0] acc;
        logic [2:0]  remaining;
        logic [3:0]  seq_len;
    } t_dec_state;

    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_dec_out;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              room2;
    } t_q_status;

    // Run of ones from bit 6 downward of a lead byte.
    function automatic logic [2:0] f_lead_ones(input logic [6:0] b);
        logic [2:0] n;
        casez (b)
            7'b0??????: n = 3'd0;
            7'b10?????: n = 3'd1;
            7'b110????: n = 3'd2;
            7'b1110???: n = 3'd3;
            7'b11110??: n = 3'd4;
            7'b111110?: n = 3'd5;
            7'b1111110: n = 3'd6;
            7'b1111111: n = 3'd7;
            default:    n = 3'd0;
        endcase
        return n;
    endfunction

endpackage

FILE: rtl/ufd_byte_if.sv
// ----------------------------------------------------------------------------
// ufd_byte_if
// Byte request channel into the decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ufd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

FILE: rtl/ufd_result_if.sv
// ----------------------------------------------------------------------------
// ufd_result_if
// Decoded result request channel out of the decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ufd_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] code_point;
    logic [1:0]  status;
    logic [3:0]  bytes_used;
    logic        last_result;

    modport source (output valid, output code_point, output status,
                    output bytes_used, output last_result, input ready);
    modport sink   (input valid, input code_point, input status,
                    input bytes_used, input last_result, output ready);
endinterface

FILE: rtl/ufd_decode.sv
// ----------------------------------------------------------------------------
// ufd_decode
// Single-pass decode of one byte against the open sequence state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ufd_decode (
    input  ufd_pkg::t_dec_state i_state,
    input  logic [7:0]          i_byte_val,
    output ufd_pkg::t_dec_state o_state,
    output ufd_pkg::t_dec_out   o_out
);
    import ufd_pkg::*;

    logic [2:0]  ones;
    logic        is_cont;
    logic        is_ascii;
    logic [7:0]  lead_mask;
    t_dec_state  lead_state;
    logic [31:0] acc_shift;
    logic [2:0]  rem_dec;
    logic [3:0]  seq_inc;

    assign ones       = f_lead_ones(i_byte_val[6:0]);
    assign is_cont    = (i_byte_val & CONT_MASK) == CONT_TAG;
    assign is_ascii   = !i_byte_val[7];
    assign lead_mask  = {2'b00, PAYLOAD_MASK >> ones};
    assign lead_state = '{acc: {24'd0, i_byte_val & lead_mask}, remaining: ones,
                          seq_len: 4'd1};
    assign acc_shift  = {i_state.acc[25:0], i_byte_val[5:0]};
    assign rem_dec    = i_state.remaining - 3'd1;
    assign seq_inc    = i_state.seq_len + 4'd1;

    always_comb begin
        o_state = i_state;
        o_out   = '0;
        if (i_state.remaining != 3'd0) begin
            if (is_cont) begin
                if (rem_dec == 3'd0) begin
                    o_out.count = 2'd1;
                    o_out.res0  = '{code_point: acc_shift, status: ST_OK,
                                    bytes_used: seq_inc, last_result: 1'b1};
                    o_state     = '0;
                end else begin
                    o_state = '{acc: acc_shift, remaining: rem_dec, seq_len: seq_inc};
                end
            end else begin
                o_out.res0 = '{code_point: 32'd0, status: ST_BAD_CONT,
                               bytes_used: i_state.seq_len, last_result: 1'b0};
                if (is_ascii) begin
                    o_out.count = 2'd2;
                    o_out.res1  = '{code_point: {24'd0, i_byte_val}, status: ST_OK,
                                    bytes_used: 4'd1, last_result: 1'b1};
                    o_state     = '0;
                end else begin
                    o_out.count            = 2'd1;
                    o_out.res0.last_result = 1'b1;
                    o_state                = lead_state;
                end
            end
        end else begin
            if (is_ascii) begin
                o_out.count = 2'd1;
                o_out.res0  = '{code_point: {24'd0, i_byte_val}, status: ST_OK,
                                bytes_used: 4'd1, last_result: 1'b1};
            end else if (is_cont) begin
                o_out.count = 2'd1;
                o_out.res0  = '{code_point: 32'd0, status: ST_BAD_FIRST,
                                bytes_used: 4'd0, last_result: 1'b1};
            end else begin
                o_state = lead_state;
            end
        end
    end

endmodule

FILE: rtl/ufd_outq.sv
// ----------------------------------------------------------------------------
// ufd_outq
// Result queue taking up to two results per cycle and releasing one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ufd_outq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [1:0]         i_push_count,
    input  ufd_pkg::t_result   i_res0,
    input  ufd_pkg::t_result   i_res1,
    input  logic               i_pop,
    output ufd_pkg::t_result   o_head,
    output ufd_pkg::t_q_status o_status
);
    import ufd_pkg::*;

    t_result           r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QPTR_W-1:0] n_wr_ptr;
    logic [QPTR_W-1:0] n_rd_ptr;
    logic [QCNT_W-1:0] n_count;
    logic [QPTR_W-1:0] wr_ptr1;

    assign wr_ptr1  = r_wr_ptr + QPTR_W'(1);
    assign n_wr_ptr = r_wr_ptr + QPTR_W'(i_push_count);
    assign n_rd_ptr = r_rd_ptr + QPTR_W'(i_pop);
    assign n_count  = r_count + QCNT_W'(i_push_count) - QCNT_W'(i_pop);

    always_ff @(posedge i_clk) begin
        if (i_push_count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_res0;
        end
        if (i_push_count == 2'd2) begin
            r_mem[wr_ptr1] <= i_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.count = r_count;
    assign o_status.room2 = r_count <= QCNT_W'(QUEUE_DEPTH - 2);

endmodule

FILE: rtl/utf8_stream_decoder_core.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder_core
// Byte-serial UTF-8 decoder, extended form up to eight bytes, with error results.
//
//   channel    dir   payload                                      accept
//   i_byte     in    in_byte[7:0]                                 valid & ready
//   o_result   out   code_point[31:0] status[1:0] bytes_used[3:0]  valid & ready
//                    last_result
//
// One byte per clock while the queue has room for two; each byte is registered, then queued.
// A byte giving two results hands them out one after the other on the single output port.
// The input register advances while the result queue has room for two.
// Reset is synchronous and empties the queue and the sequence state.
// i_byte.ready depends only on registers, never on o_result.ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module utf8_stream_decoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ufd_byte_if.sink    i_byte,
    ufd_result_if.source o_result
);
    import ufd_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    t_dec_state r_state;
    t_dec_state n_state;
    t_dec_out   dec_out;
    t_result    q_head;
    t_q_status  q_status;
    logic       adv;
    logic       in_take;
    logic       pop;
    logic [1:0] push_count;

    assign adv          = r_in_valid && q_status.room2;
    assign i_byte.ready = !r_in_valid || adv;
    assign in_take      = i_byte.valid && i_byte.ready;
    assign push_count   = adv ? dec_out.count : 2'd0;
    assign pop          = o_result.valid && o_result.ready;

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_byte.in_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_state <= n_state;
            end
        end
    end

    ufd_decode u_decode (
        .i_state    (r_state),
        .i_byte_val (r_in_byte),
        .o_state    (n_state),
        .o_out      (dec_out)
    );

    ufd_outq u_outq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_count (push_count),
        .i_res0       (dec_out.res0),
        .i_res1       (dec_out.res1),
        .i_pop        (pop),
        .o_head       (q_head),
        .o_status     (q_status)
    );

    assign o_result.valid       = q_status.count != '0;
    assign o_result.code_point  = q_head.code_point;
    assign o_result.status      = q_head.status;
    assign o_result.bytes_used  = q_head.bytes_used;
    assign o_result.last_result = q_head.last_result;

    `ASSERT_NEVER(a_queue_overflow, q_status.count > QCNT_W'(QUEUE_DEPTH))
    `ASSERT_CLK(a_idle_state_clear,
        (r_state.remaining == 3'd0) |-> (r_state.acc == 32'd0 && r_state.seq_len == 4'd0))
    `ASSERT_CLK(a_open_has_length,
        (r_state.remaining != 3'd0) |-> (r_state.seq_len != 4'd0))
    `ASSERT_CLK(a_pair_held_together,
        (o_result.valid && !o_result.last_result) |-> (q_status.count >= QCNT_W'(2)))

endmodule

FILE: bench/utf8_decode_checker.sv
// ----------------------------------------------------------------------------
// utf8_decode_checker
// Watches the byte and result channels of the UTF-8 stream decoder, keeps its
// own decoder state to predict the results of every accepted byte, and
// compares each accepted result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8_decode_checker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_byte_valid,
    input  logic             i_byte_ready,
    input  logic [7:0]       i_byte,
    input  logic             i_res_valid,
    input  logic             i_res_ready,
    input  logic [31:0]      i_code_point,
    input  ufd_pkg::t_status i_status,
    input  logic [3:0]       i_bytes_used,
    input  logic             i_last_result,
    output int               o_fail_count,
    output int               o_pending
);
    import ufd_pkg::*;

    t_result     decoded_q[$];
    logic [31:0] cp_acc     = '0;
    logic [2:0]  conts_left = '0;
    logic [3:0]  seq_bytes  = '0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic t_result make_result(input logic [31:0] cp, input t_status st,
                                            input logic [3:0] used);
        t_result r;
        r.code_point  = cp;
        r.status      = st;
        r.bytes_used  = used;
        r.last_result = 1'b0;
        return r;
    endfunction

    task automatic decode_byte(input logic [7:0] b);
        t_result found[$];
        int      ones;
        if (conts_left != 3'd0 && (b & CONT_MASK) == CONT_TAG) begin
            cp_acc     = (cp_acc << 6) + 32'(b[5:0]);
            conts_left = conts_left - 3'd1;
            seq_bytes  = seq_bytes + 4'd1;
            if (conts_left == 3'd0) begin
                found.push_back(make_result(cp_acc, ST_OK, seq_bytes));
                cp_acc    = '0;
                seq_bytes = '0;
            end
        end else begin
            // drop the partial sequence, then treat the byte as a fresh first byte
            if (conts_left != 3'd0) begin
                found.push_back(make_result('0, ST_BAD_CONT, seq_bytes));
                cp_acc     = '0;
                conts_left = '0;
                seq_bytes  = '0;
            end
            if (!b[7]) begin
                found.push_back(make_result(32'(b), ST_OK, 4'd1));
            end else if (!b[6]) begin
                found.push_back(make_result('0, ST_BAD_FIRST, 4'd0));
            end else begin
                ones = 0;
                while (ones < 7 && b[6 - ones]) ones++;
                cp_acc     = 32'(b & (8'h3F >> ones));
                conts_left = 3'(ones);
                seq_bytes  = 4'd1;
            end
        end
        if (found.size() > 0) found[found.size() - 1].last_result = 1'b1;
        foreach (found[k]) decoded_q.push_back(found[k]);
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            cp_acc     = '0;
            conts_left = '0;
            seq_bytes  = '0;
            decoded_q.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (decoded_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("%0t unexpected result: cp=%h st=%0d used=%0d last=%0b",
                                 $time, i_code_point, i_status, i_bytes_used,
                                 i_last_result);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = decoded_q.pop_front();
                    if (i_code_point !== want.code_point || i_status !== want.status ||
                        i_bytes_used !== want.bytes_used ||
                        i_last_result !== want.last_result) begin
                        if (o_fail_count < 10) begin
                            $display("%0t result mismatch: expected cp=%h st=%0d used=%0d last=%0b",
                                     $time, want.code_point, want.status,
                                     want.bytes_used, want.last_result);
                            $display("    got cp=%h st=%0d used=%0d last=%0b",
                                     i_code_point, i_status, i_bytes_used, i_last_result);
                        end
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            if (i_byte_valid && i_byte_ready) decode_byte(i_byte);
        end
        o_pending = decoded_q.size();
    end

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives the UTF-8 stream decoder with directed byte sequences and random
// streams of well-formed, broken and stray sequences under several idling
// patterns and one long output hold-off; the checker judges the results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import ufd_pkg::*;

    localparam int PHASE_ITEMS = 420;
    localparam int HOLD_ITEMS  = 100;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 400000;

    localparam logic [7:0] OPENING_BYTES [0:25] = '{
        8'h00, 8'h7F, 8'h80, 8'hBF,
        8'hC0, 8'h80,
        8'hFE, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF,
        8'hFF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF,
        8'hC3, 8'h41,
        8'hE0, 8'h80, 8'hF0
    };

    typedef enum int {PH_FREE, PH_TX_IDLE, PH_RX_STALL, PH_BOTH, PH_HOLD} t_phase;

    logic   i_clk   = 1'b0;
    logic   i_rst_n = 1'b0;
    t_phase phase   = PH_FREE;
    int     tx_idle_pct  = 0;
    int     rx_stall_pct = 0;
    int     bytes_sent   = 0;
    int     cycle_count  = 0;
    logic   hold_done    = 1'b0;
    int     fail_count;
    int     pending;

    ufd_byte_if   byte_ch ();
    ufd_result_if result_ch ();

    utf8_stream_decoder_core u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (byte_ch),
        .o_result (result_ch)
    );

    utf8_decode_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_byte_valid  (byte_ch.valid),
        .i_byte_ready  (byte_ch.ready),
        .i_byte        (byte_ch.in_byte),
        .i_res_valid   (result_ch.valid),
        .i_res_ready   (result_ch.ready),
        .i_code_point  (result_ch.code_point),
        .i_status      (result_ch.status),
        .i_bytes_used  (result_ch.bytes_used),
        .i_last_result (result_ch.last_result),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < tx_idle_pct) begin
            byte_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        byte_ch.valid   <= 1'b1;
        byte_ch.in_byte <= b;
        do @(posedge i_clk); while (!byte_ch.ready);
        bytes_sent = bytes_sent + 1;
        @(negedge i_clk);
    endtask

    task automatic send_random_run();
        int         pick;
        int         n;
        int         stop;
        logic [7:0] low_ones;
        pick = $urandom_range(99);
        if (pick < 30) begin
            send_byte(8'($urandom_range(127)));
        end else if (pick < 90) begin
            n        = ($urandom_range(3) == 0) ? $urandom_range(7, 4) : $urandom_range(3, 1);
            low_ones = 8'hFF >> (n + 1);
            send_byte(~low_ones | (8'($urandom) & (8'h3F >> n)));
            stop = (pick < 75) ? n : $urandom_range(n - 1);
            for (int k = 0; k < stop; k++) send_byte(8'h80 | 8'($urandom_range(63)));
            if (stop < n)
                send_byte($urandom_range(1) ? 8'($urandom_range(127))
                                            : 8'($urandom_range(255, 192)));
        end else begin
            send_byte(8'($urandom));
        end
    endtask

    task automatic run_phase(input t_phase ph, input int tx_pct, input int rx_pct,
                             input int items);
        int start;
        phase        = ph;
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        start        = bytes_sent;
        while (bytes_sent - start < items) send_random_run();
    endtask

    // receiver: random stalls, plus one long hold-off in the pressure phase
    initial begin
        result_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (phase == PH_HOLD && !hold_done) begin
                result_ch.ready <= 1'b0;
                for (int k = 0; k < HOLD_CYCLES; k++) @(negedge i_clk);
                hold_done = 1'b1;
            end
            result_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    initial begin
        byte_ch.valid   = 1'b0;
        byte_ch.in_byte = 8'h00;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (OPENING_BYTES[k]) send_byte(OPENING_BYTES[k]);

        run_phase(PH_FREE,     0,  0,  PHASE_ITEMS);
        run_phase(PH_TX_IDLE,  76, 0,  PHASE_ITEMS);
        run_phase(PH_RX_STALL, 0,  76, PHASE_ITEMS);
        run_phase(PH_BOTH,     28, 28, PHASE_ITEMS);
        run_phase(PH_HOLD,     0,  0,  HOLD_ITEMS);

        byte_ch.valid <= 1'b0;
        phase        = PH_FREE;
        rx_stall_pct = 0;
        while (pending != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);

        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/ufd_pkg.sv
rtl/ufd_byte_if.sv
rtl/ufd_result_if.sv
rtl/ufd_decode.sv
rtl/ufd_outq.sv
rtl/utf8_stream_decoder_core.sv
bench/utf8_decode_checker.sv
bench/tb.sv
